>>> rtl/core/ubx_nav_pvt_frame_parser_core_macros.svh
// ----------------------------------------------------------------------------
// ubx nav-pvt parser assertion macros
// shared concurrent assertion forms for the parser checkers
// ----------------------------------------------------------------------------
`ifndef UBX_NAV_PVT_FRAME_PARSER_CORE_MACROS_SVH
`define UBX_NAV_PVT_FRAME_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define UNPVT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define UNPVT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/unpvt_pkg.sv
// ----------------------------------------------------------------------------
// unpvt_pkg
// types and constants shared by the nav-pvt frame parser modules
// ----------------------------------------------------------------------------
package unpvt_pkg;

   localparam logic [7:0]  SYNC_FIRST     = 8'hB5;
   localparam logic [7:0]  SYNC_SECOND    = 8'h62;
   localparam logic [7:0]  CLASS_NAV      = 8'h01;
   localparam logic [7:0]  ID_PVT         = 8'h07;

   localparam logic [7:0]  MIN_FIX_RESET  = 8'd3;
   localparam logic [15:0] MAX_LEN_RESET  = 16'd256;
   localparam logic [13:0] FRAME_WRAP     = 14'd10000;

   localparam logic [15:0] FIX_POS        = 16'd20;
   localparam logic [15:0] SATS_POS       = 16'd23;

   localparam int          NUM_WIDE       = 8;
   // start offsets of lon, lat, height, hacc, vel n/e/d, speed acc
   localparam logic [15:0] WIDE_START [NUM_WIDE] = '{
      16'd24, 16'd28, 16'd32, 16'd40, 16'd48, 16'd52, 16'd56, 16'd68
   };

   localparam int          CSR_ADDR_W     = 3;
   localparam logic [0:0]  REG_MIN_FIX    = 1'b0;
   localparam logic [0:0]  REG_MAX_LEN    = 1'b1;

   localparam int          RSP_DATA_W     = 280;

   typedef enum logic [8:0] {
      PH_IDLE    = 9'b000000001,
      PH_SYNC2   = 9'b000000010,
      PH_CLASS   = 9'b000000100,
      PH_ID      = 9'b000001000,
      PH_LEN1    = 9'b000010000,
      PH_LEN2    = 9'b000100000,
      PH_PAYLOAD = 9'b001000000,
      PH_CKA     = 9'b010000000,
      PH_CKB     = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic [13:0]        frame_count;
      logic [31:0]        speed_acc;
      logic signed [31:0] vel_down;
      logic signed [31:0] vel_east;
      logic signed [31:0] vel_north;
      logic [31:0]        horiz_acc_mm;
      logic signed [31:0] height_mm;
      logic signed [31:0] latitude;
      logic signed [31:0] longitude;
      logic [7:0]         sat_count;
      logic               fix_ok;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type data;
   } result_word_type;

endpackage

>>> rtl/core/unpvt_parser.sv
// ----------------------------------------------------------------------------
// unpvt_parser
// byte-wide frame state machine, fletcher sums and field capture
// ----------------------------------------------------------------------------
module unpvt_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                rx_byte,
   input  logic [7:0]                min_fix_type,
   input  logic [15:0]               max_payload_len,
   output unpvt_pkg::result_word_type result
);
   import unpvt_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  class_ff, class_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [7:0]  asm_ff [4];
   logic [7:0]  asm_in [4];
   logic [7:0]  fix_ff, fix_in;
   logic [7:0]  sats_ff, sats_in;
   logic [31:0] wide_ff [NUM_WIDE];
   logic [31:0] wide_in [NUM_WIDE];
   logic [13:0] frames_ff, frames_in;

   logic [7:0]  sum_a_add;
   logic [7:0]  sum_b_add;
   logic [15:0] full_len;
   logic [15:0] pos_inc;
   logic [13:0] frames_inc;

   assign sum_a_add  = sum_a_ff + rx_byte;
   assign sum_b_add  = sum_b_ff + sum_a_add;
   assign full_len   = {rx_byte, len_ff[7:0]};
   assign pos_inc    = pos_ff + 16'd1;
   assign frames_inc = (frames_ff == FRAME_WRAP) ? 14'd0 : frames_ff + 14'd1;

   always_comb begin
      phase_in  = phase_ff;
      class_in  = class_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      asm_in    = asm_ff;
      fix_in    = fix_ff;
      sats_in   = sats_ff;
      wide_in   = wide_ff;
      frames_in = frames_ff;
      result.valid = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == SYNC_FIRST) phase_in = PH_SYNC2;
         end
         PH_SYNC2: begin
            if (rx_byte == SYNC_SECOND) begin
               phase_in = PH_CLASS;
               sum_a_in = 8'd0;
               sum_b_in = 8'd0;
            end else if (rx_byte != SYNC_FIRST) begin
               phase_in = PH_IDLE;
            end
         end
         PH_CLASS: begin
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            class_in = rx_byte;
            phase_in = PH_ID;
         end
         PH_ID: begin
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            phase_in = (class_ff == CLASS_NAV && rx_byte == ID_PVT) ? PH_LEN1 : PH_IDLE;
         end
         PH_LEN1: begin
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            len_in   = {8'd0, rx_byte};
            phase_in = PH_LEN2;
         end
         PH_LEN2: begin
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            len_in   = full_len;
            pos_in   = 16'd0;
            priority if (full_len == 16'd0)            phase_in = PH_CKA;
            else if (full_len <= max_payload_len)      phase_in = PH_PAYLOAD;
            else                                       phase_in = PH_IDLE;
         end
         PH_PAYLOAD: begin
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            if (pos_ff == FIX_POS)  fix_in  = rx_byte;
            if (pos_ff == SATS_POS) sats_in = rx_byte;
            // every wide field starts on a four-byte boundary
            for (int k = 0; k < NUM_WIDE; k++) begin
               if (pos_ff[15:2] == WIDE_START[k][15:2]) begin
                  asm_in[pos_ff[1:0]] = rx_byte;
                  if (pos_ff[1:0] == 2'd3)
                     wide_in[k] = {rx_byte, asm_ff[2], asm_ff[1], asm_ff[0]};
               end
            end
            pos_in = pos_inc;
            if (pos_inc >= len_ff) phase_in = PH_CKA;
         end
         PH_CKA: begin
            phase_in = (rx_byte == sum_a_ff) ? PH_CKB : PH_IDLE;
         end
         PH_CKB: begin
            if (rx_byte == sum_b_ff) begin
               frames_in    = frames_inc;
               result.valid = 1'b1;
            end
            phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase

      if (!step) result.valid = 1'b0;

      result.data.fix_ok       = (fix_ff >= min_fix_type);
      result.data.sat_count    = sats_ff;
      result.data.longitude    = wide_ff[0];
      result.data.latitude     = wide_ff[1];
      result.data.height_mm    = wide_ff[2];
      result.data.horiz_acc_mm = wide_ff[3];
      result.data.vel_north    = wide_ff[4];
      result.data.vel_east     = wide_ff[5];
      result.data.vel_down     = wide_ff[6];
      result.data.speed_acc    = wide_ff[7];
      result.data.frame_count  = frames_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         class_ff  <= 8'd0;
         pos_ff    <= 16'd0;
         len_ff    <= 16'd0;
         sum_a_ff  <= 8'd0;
         sum_b_ff  <= 8'd0;
         asm_ff    <= '{default: 8'd0};
         fix_ff    <= 8'd0;
         sats_ff   <= 8'd0;
         wide_ff   <= '{default: 32'd0};
         frames_ff <= 14'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         class_ff  <= class_in;
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
         asm_ff    <= asm_in;
         fix_ff    <= fix_in;
         sats_ff   <= sats_in;
         wide_ff   <= wide_in;
         frames_ff <= frames_in;
      end
   end

endmodule

>>> rtl/core/unpvt_out_fifo.sv
// ----------------------------------------------------------------------------
// unpvt_out_fifo
// two-entry result buffer in front of the rsp stream
// ----------------------------------------------------------------------------
module unpvt_out_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  unpvt_pkg::result_type  push_data,
   output logic                   can_push,
   output logic                   out_valid,
   input  logic                   out_ready,
   output unpvt_pkg::result_type  out_data
);
   import unpvt_pkg::*;

   result_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign pop       = out_valid && out_ready;
   assign can_push  = (count_ff != 2'd2) || pop;
   assign out_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

>>> rtl/core/ubx_nav_pvt_frame_parser_core.sv
// ----------------------------------------------------------------------------
// ubx_nav_pvt_frame_parser_core
// nav-pvt frame parser with byte stream in, decoded fix record out
// ----------------------------------------------------------------------------
// Takes one received byte per req word and can accept a byte on every clock
// while req_tready is high. A byte lands in an input register; the frame
// state machine consumes it once the result buffer can take a record, and
// when the second checksum byte matches, a record is written to a two-entry
// result buffer whose registered count drives rsp_tvalid. Bytes keep flowing
// while a record waits on rsp_tready; only once both buffer entries are full
// and the held byte still owes a step does req_tready drop. Registers:
// 0x0 min_fix_type (reset 3), 0x4 max_payload_len (reset 256); write them
// only while the stream is idle.
module ubx_nav_pvt_frame_parser_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,   // [7:0] rx_byte
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] fix_ok, [8:1] sat_count, [40:9] longitude, [72:41] latitude,
   // [104:73] height_mm, [136:105] horiz_acc_mm, [168:137] vel_north,
   // [200:169] vel_east, [232:201] vel_down, [264:233] speed_acc,
   // [278:265] frame_count, [279] zero
   output logic [unpvt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [unpvt_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   import unpvt_pkg::*;

   logic [7:0]      min_fix_ff;
   logic [15:0]     max_len_ff;
   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            step;
   logic            can_push;
   result_word_type result;
   result_type      out_data;
   logic            csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[2])
         REG_MIN_FIX: csr_prdata = {24'd0, min_fix_ff};
         REG_MAX_LEN: csr_prdata = {16'd0, max_len_ff};
         default:     csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_fix_ff <= MIN_FIX_RESET;
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_MIN_FIX: min_fix_ff <= csr_pwdata[7:0];
            REG_MAX_LEN: max_len_ff <= csr_pwdata[15:0];
            default:     min_fix_ff <= min_fix_ff;
         endcase
      end
   end

   // a held byte steps only once the buffer can take a possible record
   assign step       = in_valid_ff && can_push;
   assign req_tready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) in_byte_ff <= req_tdata;
   end

   unpvt_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .rx_byte         (in_byte_ff),
      .min_fix_type    (min_fix_ff),
      .max_payload_len (max_len_ff),
      .result          (result)
   );

   unpvt_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (result.valid),
      .push_data (result.data),
      .can_push  (can_push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {1'b0, out_data};

endmodule

>>> rtl/core/unpvt_checker.sv
// ----------------------------------------------------------------------------
// unpvt_checker
// port-level checks on the nav-pvt parser, bound to the top level
// ----------------------------------------------------------------------------
`include "ubx_nav_pvt_frame_parser_core_macros.svh"

module unpvt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [unpvt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                             csr_pready
);
   import unpvt_pkg::*;

   // a stalled record holds
   `UNPVT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp record changed under stall")
   // reset empties the result buffer and the input register
   `UNPVT_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_tvalid, "rsp valid after reset")
   `UNPVT_ASSERT_NEXT(a_req_reset, clock, 1'b0, reset, req_tready, "req not ready after reset")
   `UNPVT_ASSERT_SAME(a_pready, clock, reset, 1'b1, csr_pready, "csr pready low")

endmodule

bind ubx_nav_pvt_frame_parser_core unpvt_checker u_unpvt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
